// File: rtl/core/hoi_pkg.sv
// hoi_pkg: shared types and constants of the half-open interval unit.
// No dependencies; used by every module under rtl/core.
package hoi_pkg;

    localparam int TIME_BITS_DEF = 32;
    localparam int FIELD_BITS    = 32;
    localparam int FUNC_BITS     = 3;
    localparam int CNT_BITS      = 2;
    localparam int IN_DATA_BITS  = 6 * FIELD_BITS;
    localparam int OUT_FIELDS    = 1 + CNT_BITS + 5 * FIELD_BITS + 1;
    localparam int OUT_DATA_BITS = ((OUT_FIELDS + 7) / 8) * 8;

    typedef enum logic [FUNC_BITS-1:0] {
        FN_OVERLAPS   = 3'd0,
        FN_INTERSECTS = 3'd1,
        FN_ENCLOSES   = 3'd2,
        FN_CONTAINS   = 3'd3,
        FN_INTERSECT  = 3'd4,
        FN_COMBINE    = 3'd5,
        FN_SUBTRACT   = 3'd6,
        FN_LENGTH     = 3'd7
    } t_func;

    // compare results produced by the compare stage
    typedef struct packed {
        logic as_z;
        logic ae_z;
        logic bs_z;
        logic be_z;
        logic be_le_as;
        logic bs_ge_ae;
        logic as_eq_bs;
        logic as_eq_ae;
        logic ae_eq_be;
        logic as_lt_bs;
        logic be_lt_ae;
        logic ae_lt_be;
        logic as_lt_pt;
        logic pt_lt_ae;
    } t_cmp;

endpackage

// File: rtl/core/hoi_cmp.sv
// hoi_cmp: compare stage; all bound compares and the length subtract, registered.
// Depends on hoi_pkg.
module hoi_cmp #(
    parameter int TIME_BITS = hoi_pkg::TIME_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  hoi_pkg::t_func       i_func,
    input  logic [TIME_BITS-1:0] i_as,
    input  logic [TIME_BITS-1:0] i_ae,
    input  logic [TIME_BITS-1:0] i_bs,
    input  logic [TIME_BITS-1:0] i_be,
    input  logic [TIME_BITS-1:0] i_pt,
    input  logic [TIME_BITS-1:0] i_now,
    output logic                 o_valid,
    input  logic                 i_ready,
    output hoi_pkg::t_func       o_func,
    output logic [TIME_BITS-1:0] o_as,
    output logic [TIME_BITS-1:0] o_ae,
    output logic [TIME_BITS-1:0] o_bs,
    output logic [TIME_BITS-1:0] o_be,
    output hoi_pkg::t_cmp        o_cmp,
    output logic [TIME_BITS-1:0] o_len,
    output logic                 o_err
);

    logic                 r_valid;
    hoi_pkg::t_func       r_func;
    logic [TIME_BITS-1:0] r_as, r_ae, r_bs, r_be, r_len;
    logic                 r_err;
    hoi_pkg::t_cmp        r_cmp;

    hoi_pkg::t_cmp        n_cmp;
    logic [TIME_BITS-1:0] w_endv;
    logic [TIME_BITS:0]   w_diff;

    always_comb begin
        n_cmp.as_z     = (i_as == '0);
        n_cmp.ae_z     = (i_ae == '0);
        n_cmp.bs_z     = (i_bs == '0);
        n_cmp.be_z     = (i_be == '0);
        n_cmp.be_le_as = (i_be <= i_as);
        n_cmp.bs_ge_ae = (i_bs >= i_ae);
        n_cmp.as_eq_bs = (i_as == i_bs);
        n_cmp.as_eq_ae = (i_as == i_ae);
        n_cmp.ae_eq_be = (i_ae == i_be);
        n_cmp.as_lt_bs = (i_as < i_bs);
        n_cmp.be_lt_ae = (i_be < i_ae);
        n_cmp.ae_lt_be = (i_ae < i_be);
        n_cmp.as_lt_pt = (i_as < i_pt);
        n_cmp.pt_lt_ae = (i_pt < i_ae);
    end

    // open A takes now as its end
    assign w_endv  = (i_as != '0 && i_ae == '0) ? i_now : i_ae;
    assign w_diff  = {1'b0, w_endv} - {1'b0, i_as};
    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_func <= i_func;
            r_as   <= i_as;
            r_ae   <= i_ae;
            r_bs   <= i_bs;
            r_be   <= i_be;
            r_cmp  <= n_cmp;
            r_len  <= w_diff[TIME_BITS-1:0];
            r_err  <= w_diff[TIME_BITS];
        end
    end

    assign o_valid = r_valid;
    assign o_func  = r_func;
    assign o_as    = r_as;
    assign o_ae    = r_ae;
    assign o_bs    = r_bs;
    assign o_be    = r_be;
    assign o_cmp   = r_cmp;
    assign o_len   = r_len;
    assign o_err   = r_err;

endmodule

// File: rtl/core/hoi_sel.sv
// hoi_sel: decision and result select stage, registered as the output word.
// Depends on hoi_pkg.
module hoi_sel #(
    parameter int TIME_BITS = hoi_pkg::TIME_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  hoi_pkg::t_func               i_func,
    input  logic [TIME_BITS-1:0]         i_as,
    input  logic [TIME_BITS-1:0]         i_ae,
    input  logic [TIME_BITS-1:0]         i_bs,
    input  logic [TIME_BITS-1:0]         i_be,
    input  hoi_pkg::t_cmp                i_cmp,
    input  logic [TIME_BITS-1:0]         i_len,
    input  logic                         i_err,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic                         o_flag,
    output logic [hoi_pkg::CNT_BITS-1:0] o_cnt,
    output logic [TIME_BITS-1:0]         o_s1,
    output logic [TIME_BITS-1:0]         o_e1,
    output logic [TIME_BITS-1:0]         o_s2,
    output logic [TIME_BITS-1:0]         o_e2,
    output logic [TIME_BITS-1:0]         o_len,
    output logic                         o_err
);

    logic                         r_valid, r_flag, r_err;
    logic [hoi_pkg::CNT_BITS-1:0] r_cnt;
    logic [TIME_BITS-1:0]         r_s1, r_e1, r_s2, r_e2, r_len;

    logic                         n_flag, n_err;
    logic [hoi_pkg::CNT_BITS-1:0] n_cnt;
    logic [TIME_BITS-1:0]         n_s1, n_e1, n_s2, n_e2, n_len;

    logic w_ovl, w_intr, w_encl, w_cont, w_tail;

    always_comb begin
        w_ovl  = !i_cmp.as_z && !i_cmp.bs_z
                 && !(!i_cmp.be_z && i_cmp.be_le_as)
                 && !(!i_cmp.ae_z && i_cmp.bs_ge_ae);
        w_intr = w_ovl || (!i_cmp.as_z && !i_cmp.bs_z && i_cmp.as_eq_bs);
        w_encl = !i_cmp.as_eq_ae
                 && (i_cmp.as_eq_bs || ((i_cmp.as_z || i_cmp.as_lt_bs)
                                        && (i_cmp.ae_z || !i_cmp.bs_ge_ae)))
                 && (i_cmp.ae_eq_be || ((i_cmp.as_z || !i_cmp.be_le_as)
                                        && (i_cmp.ae_z || i_cmp.be_lt_ae)));
        w_cont = (i_cmp.as_z || i_cmp.as_lt_pt) && (i_cmp.ae_z || i_cmp.pt_lt_ae);
        // part of A beyond the end of B
        w_tail = !i_cmp.be_z && (i_cmp.ae_z || i_cmp.be_lt_ae);

        n_flag = 1'b0;
        n_cnt  = '0;
        n_s1   = '0;
        n_e1   = '0;
        n_s2   = '0;
        n_e2   = '0;
        n_len  = '0;
        n_err  = 1'b0;
        unique case (i_func)
            hoi_pkg::FN_OVERLAPS:   n_flag = w_ovl;
            hoi_pkg::FN_INTERSECTS: n_flag = w_intr;
            hoi_pkg::FN_ENCLOSES:   n_flag = w_encl;
            hoi_pkg::FN_CONTAINS:   n_flag = w_cont;
            hoi_pkg::FN_INTERSECT: begin
                if (w_ovl) begin
                    n_cnt = hoi_pkg::CNT_BITS'(1);
                    n_s1  = i_cmp.as_lt_bs ? i_bs : i_as;
                    if (!i_cmp.ae_z && !i_cmp.be_z) begin
                        n_e1 = i_cmp.ae_lt_be ? i_ae : i_be;
                    end else if (!i_cmp.ae_z) begin
                        n_e1 = i_ae;
                    end else begin
                        n_e1 = i_be;
                    end
                end else if (w_intr) begin
                    n_cnt = hoi_pkg::CNT_BITS'(1);
                    n_s1  = i_as;
                    n_e1  = i_as;
                end
            end
            hoi_pkg::FN_COMBINE: begin
                n_cnt = hoi_pkg::CNT_BITS'(1);
                n_s1  = i_as;
                n_e1  = i_ae;
                if (!i_cmp.as_z && !i_cmp.bs_z) begin
                    n_s1 = i_cmp.as_lt_bs ? i_as : i_bs;
                    if (i_cmp.ae_z || i_cmp.be_z) begin
                        n_e1 = '0;
                    end else begin
                        n_e1 = i_cmp.ae_lt_be ? i_be : i_ae;
                    end
                end
            end
            hoi_pkg::FN_SUBTRACT: begin
                if (w_ovl) begin
                    if (i_cmp.as_lt_bs) begin
                        n_cnt = hoi_pkg::CNT_BITS'(1);
                        n_s1  = i_as;
                        n_e1  = i_bs;
                        if (w_tail) begin
                            n_cnt = hoi_pkg::CNT_BITS'(2);
                            n_s2  = i_be;
                            n_e2  = i_ae;
                        end
                    end else if (w_tail) begin
                        n_cnt = hoi_pkg::CNT_BITS'(1);
                        n_s1  = i_be;
                        n_e1  = i_ae;
                    end
                end else begin
                    n_cnt = hoi_pkg::CNT_BITS'(1);
                    n_s1  = i_as;
                    n_e1  = i_ae;
                end
            end
            hoi_pkg::FN_LENGTH: begin
                n_err = i_err;
                n_len = i_err ? '0 : i_len;
            end
        endcase
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_flag <= n_flag;
            r_cnt  <= n_cnt;
            r_s1   <= n_s1;
            r_e1   <= n_e1;
            r_s2   <= n_s2;
            r_e2   <= n_e2;
            r_len  <= n_len;
            r_err  <= n_err;
        end
    end

    assign o_valid = r_valid;
    assign o_flag  = r_flag;
    assign o_cnt   = r_cnt;
    assign o_s1    = r_s1;
    assign o_e1    = r_e1;
    assign o_s2    = r_s2;
    assign o_e2    = r_e2;
    assign o_len   = r_len;
    assign o_err   = r_err;

endmodule

// File: rtl/core/half_open_interval_unit.sv
// half_open_interval_unit: top level; input register, compare and select stages.
// Depends on hoi_pkg, hoi_cmp, hoi_sel.
//
//  channel   dir  handshake                          payload
//  s_axis    in   i_s_axis_tvalid / o_s_axis_tready  tdata 192b, tuser 3b (func)
//  m_axis    out  o_m_axis_tvalid / i_m_axis_tready  tdata 168b
//
// Three register stages (input, compare, select); a word passes through them in that order.
// One word per cycle sustained while m_axis accepts; each stage holds its word while the next one is full.
// Reset clears the stage valid bits only; no other state.
// Time values are held at TIME_BITS; the ports carry 32-bit fields.
module half_open_interval_unit #(
    parameter int TIME_BITS = hoi_pkg::TIME_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // a_start, a_end, b_start, b_end, point, now
    input  logic [hoi_pkg::IN_DATA_BITS-1:0]  i_s_axis_tdata,
    // func
    input  logic [hoi_pkg::FUNC_BITS-1:0]     i_s_axis_tuser,
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // flag, piece_count, first_start, first_end, second_start, second_end,
    // length, order_error, zero pad
    output logic [hoi_pkg::OUT_DATA_BITS-1:0] o_m_axis_tdata
);

    localparam int FB = hoi_pkg::FIELD_BITS;
    localparam int XW = (TIME_BITS > FB) ? TIME_BITS : FB;

    logic                 r_v1;
    hoi_pkg::t_func       r_func;
    logic [TIME_BITS-1:0] r_as, r_ae, r_bs, r_be, r_pt, r_now;

    logic [XW-1:0]        w_x_as, w_x_ae, w_x_bs, w_x_be, w_x_pt, w_x_now;
    logic                 w_cmp_ready;

    logic                 w_v2;
    hoi_pkg::t_func       w_func2;
    logic [TIME_BITS-1:0] w_as2, w_ae2, w_bs2, w_be2, w_len2;
    hoi_pkg::t_cmp        w_cmp2;
    logic                 w_err2;
    logic                 w_sel_ready;

    logic                         w_flag, w_err;
    logic [hoi_pkg::CNT_BITS-1:0] w_cnt;
    logic [TIME_BITS-1:0]         w_s1, w_e1, w_s2, w_e2, w_len;
    logic [XW-1:0]                w_x_s1, w_x_e1, w_x_s2, w_x_e2, w_x_len;

    assign w_x_as  = XW'(i_s_axis_tdata[0*FB +: FB]);
    assign w_x_ae  = XW'(i_s_axis_tdata[1*FB +: FB]);
    assign w_x_bs  = XW'(i_s_axis_tdata[2*FB +: FB]);
    assign w_x_be  = XW'(i_s_axis_tdata[3*FB +: FB]);
    assign w_x_pt  = XW'(i_s_axis_tdata[4*FB +: FB]);
    assign w_x_now = XW'(i_s_axis_tdata[5*FB +: FB]);

    assign o_s_axis_tready = !r_v1 || w_cmp_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_v1 <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_func <= hoi_pkg::t_func'(i_s_axis_tuser);
            r_as   <= w_x_as[TIME_BITS-1:0];
            r_ae   <= w_x_ae[TIME_BITS-1:0];
            r_bs   <= w_x_bs[TIME_BITS-1:0];
            r_be   <= w_x_be[TIME_BITS-1:0];
            r_pt   <= w_x_pt[TIME_BITS-1:0];
            r_now  <= w_x_now[TIME_BITS-1:0];
        end
    end

    hoi_cmp #(.TIME_BITS(TIME_BITS)) u_cmp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v1),
        .o_ready (w_cmp_ready),
        .i_func  (r_func),
        .i_as    (r_as),
        .i_ae    (r_ae),
        .i_bs    (r_bs),
        .i_be    (r_be),
        .i_pt    (r_pt),
        .i_now   (r_now),
        .o_valid (w_v2),
        .i_ready (w_sel_ready),
        .o_func  (w_func2),
        .o_as    (w_as2),
        .o_ae    (w_ae2),
        .o_bs    (w_bs2),
        .o_be    (w_be2),
        .o_cmp   (w_cmp2),
        .o_len   (w_len2),
        .o_err   (w_err2)
    );

    hoi_sel #(.TIME_BITS(TIME_BITS)) u_sel (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_v2),
        .o_ready (w_sel_ready),
        .i_func  (w_func2),
        .i_as    (w_as2),
        .i_ae    (w_ae2),
        .i_bs    (w_bs2),
        .i_be    (w_be2),
        .i_cmp   (w_cmp2),
        .i_len   (w_len2),
        .i_err   (w_err2),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_flag  (w_flag),
        .o_cnt   (w_cnt),
        .o_s1    (w_s1),
        .o_e1    (w_e1),
        .o_s2    (w_s2),
        .o_e2    (w_e2),
        .o_len   (w_len),
        .o_err   (w_err)
    );

    assign w_x_s1  = XW'(w_s1);
    assign w_x_e1  = XW'(w_e1);
    assign w_x_s2  = XW'(w_s2);
    assign w_x_e2  = XW'(w_e2);
    assign w_x_len = XW'(w_len);

    assign o_m_axis_tdata = hoi_pkg::OUT_DATA_BITS'({
        w_err,
        w_x_len[FB-1:0],
        w_x_e2[FB-1:0],
        w_x_s2[FB-1:0],
        w_x_e1[FB-1:0],
        w_x_s1[FB-1:0],
        w_cnt,
        w_flag
    });

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (w_cnt != 2'd3))
        else $error("piece count out of range");

    a_err_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && w_err) |-> (w_len == '0 && !w_flag && w_cnt == '0))
        else $error("order error with nonzero result");

    a_flag_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> !(w_flag && w_cnt != '0))
        else $error("flag and pieces both set");

    a_stage_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && !w_cmp_ready) |=> (r_v1 && $stable(r_as) && $stable(r_func)))
        else $error("input stage lost a stalled word");

    a_second_piece: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && w_cnt != 2'd2) |-> (w_s2 == '0 && w_e2 == '0))
        else $error("second piece set without two pieces");

endmodule
